### src/cftb_pkg.sv
// Package: shared types and constants of the finger table builder.
package cftb_pkg;

   localparam int MaxNodes = 64;
   localparam int IdWidth  = 32;
   localparam int PosWidth = $clog2(MaxNodes);
   localparam int CntWidth = $clog2(MaxNodes + 1);
   localparam int GoalWidth = CntWidth + 1;

   localparam logic [2:0] FUNC_LOAD  = 3'd0;
   localparam logic [2:0] FUNC_PRED  = 3'd1;
   localparam logic [2:0] FUNC_SUCC  = 3'd2;
   localparam logic [2:0] FUNC_FING  = 3'd3;
   localparam logic [2:0] FUNC_CLEAR = 3'd4;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_FULL  = 3'd1;
   localparam logic [2:0] ST_EMPTY = 3'd2;
   localparam logic [2:0] ST_BAD   = 3'd3;
   localparam logic [2:0] ST_RANGE = 3'd4;

   localparam logic CSR_ADDR_BITS = 1'b0;
   localparam logic CSR_SUCC_LEN  = 1'b1;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_ROTATE = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type          op;
      logic [IdWidth-1:0]   id;
   } cell_cmd_type;

endpackage

### src/cftb_req_if.sv
// Interface: request channel carrying one item per beat.
interface cftb_req_if;
   logic                          valid;
   logic                          ready;
   logic [2:0]                    func;
   logic [cftb_pkg::IdWidth-1:0]  node_id;
   logic [5:0]                    node_rank;
   logic [4:0]                    entry_index;

   modport source (output valid, func, node_id, node_rank, entry_index, input ready);
   modport sink   (input valid, func, node_id, node_rank, entry_index, output ready);
endinterface

### src/cftb_rsp_if.sv
// Interface: response channel carrying one result per beat.
interface cftb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cftb_pkg::IdWidth-1:0]  result_id;
   logic [2:0]                    status;

   modport source (output valid, result_id, status, input ready);
   modport sink   (input valid, result_id, status, output ready);
endinterface

### src/cftb_cell.sv
// One table cell: holds one identifier, inserts in order or rotates the ring.
module cftb_cell (
   input  logic                          clock,
   input  cftb_pkg::cell_cmd_type        cmd,
   input  logic                          valid,
   input  logic                          next_valid,
   input  logic                          is_first,
   input  logic [cftb_pkg::IdWidth-1:0]  prev_val,
   input  logic                          prev_le,
   input  logic [cftb_pkg::IdWidth-1:0]  next_val,
   input  logic [cftb_pkg::IdWidth-1:0]  head_val,
   output logic [cftb_pkg::IdWidth-1:0]  val,
   output logic                          le
);
   logic [cftb_pkg::IdWidth-1:0] val_ff;
   logic [cftb_pkg::IdWidth-1:0] val_in;

   assign le  = valid && (val_ff <= cmd.id);
   assign val = val_ff;

   always_comb begin
      unique case (cmd.op)
         cftb_pkg::CELL_INSERT: begin
            // Entries not above the new id stay; the first larger slot takes it.
            if (le) val_in = val_ff;
            else if (is_first || prev_le) val_in = cmd.id;
            else val_in = prev_val;
         end
         cftb_pkg::CELL_ROTATE: val_in = next_valid ? next_val : head_val;
         default: val_in = val_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end
endmodule

### src/cftb_chain.sv
// Row of table cells linked to their neighbours.
module cftb_chain (
   input  logic                           clock,
   input  cftb_pkg::cell_cmd_type         cmd,
   input  logic [cftb_pkg::CntWidth-1:0]  count,
   output logic [cftb_pkg::IdWidth-1:0]   head
);
   logic [cftb_pkg::IdWidth-1:0] vals [cftb_pkg::MaxNodes];
   logic [cftb_pkg::MaxNodes-1:0] les;
   logic [cftb_pkg::MaxNodes-1:0] valids;

   assign head = vals[0];

   for (genvar i = 0; i < cftb_pkg::MaxNodes; i++) begin : g_cell
      assign valids[i] = count > cftb_pkg::CntWidth'(i);
      cftb_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .valid      (valids[i]),
         .next_valid ((i + 1 < cftb_pkg::MaxNodes) ? valids[(i + 1) % cftb_pkg::MaxNodes]
                                                   : 1'b0),
         .is_first   (i == 0),
         .prev_val   (vals[(i + cftb_pkg::MaxNodes - 1) % cftb_pkg::MaxNodes]),
         .prev_le    ((i == 0) ? 1'b0 : les[(i + cftb_pkg::MaxNodes - 1) % cftb_pkg::MaxNodes]),
         .next_val   (vals[(i + 1) % cftb_pkg::MaxNodes]),
         .head_val   (vals[0]),
         .val        (vals[i]),
         .le         (les[i])
      );
   end
endmodule

### src/chord_finger_table_builder_top.sv
// Top level: request decode, ring walk control and response register.
//
//  channel   direction  beat contents
//  req       in         func, node_id, node_rank, entry_index
//  rsp       out        result_id, status
//  csr       in         csr_we, csr_index, csr_wdata (write only)
//
// Load, clear and rejected items pass from the idle state through the finish state
// to the response register. Predecessor and successor queries rotate the cell ring
// one entry per cycle to the wanted entry and back to its start. Finger queries
// then add a full scan of all count entries. Reset empties the table; the cells
// themselves are not cleared. A stalled response holds the finished item until
// taken; a new request is taken once idle.
module chord_finger_table_builder_top (
   input  logic        clock,
   input  logic        reset,
   cftb_req_if.sink    req,
   cftb_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [5:0]  csr_wdata
);
   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_SEEK    = 5'b00010,
      S_RESTORE = 5'b00100,
      S_SCAN    = 5'b01000,
      S_FINISH  = 5'b10000
   } state_type;

   localparam int IW = cftb_pkg::IdWidth;
   localparam int CW = cftb_pkg::CntWidth;
   localparam int PW = cftb_pkg::PosWidth;
   localparam int GW = cftb_pkg::GoalWidth;

   state_type       state_ff, state_in;
   logic [5:0]      abits_ff;
   logic [4:0]      slen_ff;
   logic [CW-1:0]   count_ff, count_in;
   logic [PW-1:0]   pos_ff, pos_in;
   logic [GW-1:0]   steps_ff, steps_in;
   logic [GW-1:0]   goal_ff, goal_in;
   logic [PW-1:0]   scan_ff, scan_in;
   logic            fing_ff, fing_in;
   logic            found_ff, found_in;
   logic [IW-1:0]   res_ff, res_in;
   logic [IW-1:0]   first_ff, first_in;
   logic [IW-1:0]   tgt_ff, tgt_in;
   logic [2:0]      st_ff, st_in;
   logic            rsp_valid_ff;
   logic [IW-1:0]   rsp_id_ff;
   logic [2:0]      rsp_st_ff;

   cftb_pkg::cell_cmd_type cmd;
   logic [IW-1:0]   head;
   logic [5:0]      eff_m;
   logic [4:0]      eff_s;
   logic [IW-1:0]   mod_mask;
   logic            accept;
   logic            pos_wrap;
   logic [IW-1:0]   first_val;
   logic            hit;

   cftb_chain u_chain (
      .clock (clock),
      .cmd   (cmd),
      .count (count_ff),
      .head  (head)
   );

   always_comb begin
      if (abits_ff == 6'd0) eff_m = 6'd1;
      else if (abits_ff > 6'(IW)) eff_m = 6'(IW);
      else eff_m = abits_ff;
      if (slen_ff == 5'd0) eff_s = 5'd1;
      else if (slen_ff > 5'd16) eff_s = 5'd16;
      else eff_s = slen_ff;
   end

   assign mod_mask  = IW'(({{IW{1'b0}}, 1'b1} << eff_m) - 1'b1);
   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign pos_wrap  = ({1'b0, pos_ff} + 1'b1) == count_ff;
   assign first_val = (scan_ff == '0) ? head : first_ff;
   assign hit       = head >= tgt_ff;

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.result_id = rsp_id_ff;
   assign rsp.status    = rsp_st_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      steps_in = steps_ff;
      goal_in  = goal_ff;
      scan_in  = scan_ff;
      fing_in  = fing_ff;
      found_in = found_ff;
      res_in   = res_ff;
      first_in = first_ff;
      tgt_in   = tgt_ff;
      st_in    = st_ff;
      cmd.op   = cftb_pkg::CELL_HOLD;
      cmd.id   = req.node_id;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in   = '0;
               st_in    = cftb_pkg::ST_OK;
               state_in = S_FINISH;
               steps_in = '0;
               fing_in  = (req.func == cftb_pkg::FUNC_FING);
               unique case (req.func)
                  cftb_pkg::FUNC_LOAD: begin
                     if ((req.node_id & ~mod_mask) != '0) st_in = cftb_pkg::ST_RANGE;
                     else if (count_ff == CW'(cftb_pkg::MaxNodes)) st_in = cftb_pkg::ST_FULL;
                     else begin
                        cmd.op   = cftb_pkg::CELL_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  cftb_pkg::FUNC_CLEAR: count_in = '0;
                  cftb_pkg::FUNC_PRED, cftb_pkg::FUNC_SUCC, cftb_pkg::FUNC_FING: begin
                     if (count_ff == '0) st_in = cftb_pkg::ST_EMPTY;
                     else if ({1'b0, req.node_rank} >= count_ff) st_in = cftb_pkg::ST_BAD;
                     else if (req.func == cftb_pkg::FUNC_SUCC && req.entry_index >= eff_s)
                        st_in = cftb_pkg::ST_BAD;
                     else if (req.func == cftb_pkg::FUNC_FING &&
                              {1'b0, req.entry_index} >= eff_m)
                        st_in = cftb_pkg::ST_BAD;
                     else begin
                        state_in = S_SEEK;
                        if (req.func == cftb_pkg::FUNC_PRED)
                           goal_in = (req.node_rank == '0) ? GW'(count_ff - 1'b1)
                                                            : GW'(req.node_rank - 1'b1);
                        else if (req.func == cftb_pkg::FUNC_SUCC)
                           goal_in = GW'(req.node_rank) + GW'(req.entry_index) + 1'b1;
                        else begin
                           goal_in = GW'(req.node_rank);
                           // Finger step 2^j kept in the target register until the base is read.
                           tgt_in = IW'({{IW{1'b0}}, 1'b1} << req.entry_index);
                        end
                     end
                  end
                  default: st_in = cftb_pkg::ST_BAD;
               endcase
            end
         end
         S_SEEK: begin
            if (steps_ff == goal_ff) begin
               res_in   = head;
               state_in = S_RESTORE;
               if (fing_ff) tgt_in = (head + tgt_ff) & mod_mask;
            end else begin
               cmd.op   = cftb_pkg::CELL_ROTATE;
               steps_in = steps_ff + 1'b1;
               pos_in   = pos_wrap ? '0 : pos_ff + 1'b1;
            end
         end
         S_RESTORE: begin
            if (pos_ff == '0) begin
               state_in = fing_ff ? S_SCAN : S_FINISH;
               scan_in  = '0;
               found_in = 1'b0;
            end else begin
               cmd.op = cftb_pkg::CELL_ROTATE;
               pos_in = pos_wrap ? '0 : pos_ff + 1'b1;
            end
         end
         S_SCAN: begin
            // Ring is at its start; a full turn visits the ids in ascending order.
            cmd.op   = cftb_pkg::CELL_ROTATE;
            first_in = first_val;
            scan_in  = scan_ff + 1'b1;
            if (!found_ff && hit) begin
               found_in = 1'b1;
               res_in   = head;
            end
            if (({1'b0, scan_ff} + 1'b1) == count_ff) begin
               state_in = S_FINISH;
               if (!found_ff) res_in = hit ? head : first_val;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         abits_ff     <= 6'd32;
         slen_ff      <= 5'd4;
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         if (csr_we) begin
            unique case (csr_index)
               cftb_pkg::CSR_ADDR_BITS: abits_ff <= csr_wdata;
               cftb_pkg::CSR_SUCC_LEN:  slen_ff  <= csr_wdata[4:0];
               default: ;
            endcase
         end
         if (state_ff == S_FINISH && (!rsp_valid_ff || rsp.ready)) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff <= steps_in;
      goal_ff  <= goal_in;
      scan_ff  <= scan_in;
      fing_ff  <= fing_in;
      found_ff <= found_in;
      res_ff   <= res_in;
      first_ff <= first_in;
      tgt_ff   <= tgt_in;
      st_ff    <= st_in;
      if (state_ff == S_FINISH && (!rsp_valid_ff || rsp.ready)) begin
         rsp_id_ff <= (st_ff == cftb_pkg::ST_OK) ? res_ff : '0;
         rsp_st_ff <= st_ff;
      end
   end
endmodule

### dv/chord_finger_table_builder_top_test.sv
// Testbench: finger table builder checked against its own ring predictor.
`timescale 1ns / 100ps

module chord_finger_table_builder_top_test;

   localparam int WatchLimit = 4000;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] node_id;
      logic [5:0]  node_rank;
      logic [4:0]  entry_index;
      logic        has_answer;
      logic [31:0] answer_id;
      logic [2:0]  answer_status;
   } stim_row_type;

   typedef struct packed {
      logic [31:0] result_id;
      logic [2:0]  status;
   } answer_type;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic       csr_index;
   logic [5:0] csr_wdata;

   cftb_req_if req ();
   cftb_rsp_if rsp ();

   chord_finger_table_builder_top dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predictor state.
   logic [31:0] ring_ids[cftb_pkg::MaxNodes];
   int          ring_count;
   logic [5:0]  width_reg;
   logic [4:0]  succ_reg;

   answer_type   answers_due[$];
   stim_row_type table_rows[$];
   int           error_count;
   int           quiet_cycles;
   int           stall_phase;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
   endtask

   task automatic add_row(input stim_row_type row);
      table_rows.insert(table_rows.size(), row);
   endtask

   function automatic int bits_now();
      int m;
      m = width_reg;
      if (m < 1) m = 1;
      if (m > cftb_pkg::IdWidth) m = cftb_pkg::IdWidth;
      return m;
   endfunction

   function automatic answer_type ring_answer(input logic [2:0] func, input logic [31:0] id,
                                              input int rank, input int idx);
      answer_type a;
      int m;
      int s;
      int pos;
      logic [63:0] goal;
      a = '0;
      a.status = cftb_pkg::ST_OK;
      m = bits_now();
      s = (succ_reg < 1) ? 1 : (succ_reg > 16 ? 16 : succ_reg);
      if (func == cftb_pkg::FUNC_LOAD) begin
         if ((64'(id) >> m) != 0) a.status = cftb_pkg::ST_RANGE;
         else if (ring_count >= cftb_pkg::MaxNodes) a.status = cftb_pkg::ST_FULL;
         else begin
            pos = 0;
            while (pos < ring_count && ring_ids[pos] <= id) pos++;
            for (int i = ring_count; i > pos; i--) ring_ids[i] = ring_ids[i-1];
            ring_ids[pos] = id;
            ring_count++;
         end
      end else if (func == cftb_pkg::FUNC_CLEAR) begin
         ring_count = 0;
      end else if (func == cftb_pkg::FUNC_PRED || func == cftb_pkg::FUNC_SUCC ||
                   func == cftb_pkg::FUNC_FING) begin
         if (ring_count == 0) a.status = cftb_pkg::ST_EMPTY;
         else if (rank >= ring_count) a.status = cftb_pkg::ST_BAD;
         else if (func == cftb_pkg::FUNC_PRED)
            a.result_id = ring_ids[rank > 0 ? rank - 1 : ring_count - 1];
         else if (func == cftb_pkg::FUNC_SUCC) begin
            if (idx >= s) a.status = cftb_pkg::ST_BAD;
            else a.result_id = ring_ids[(rank + idx + 1) % ring_count];
         end else begin
            if (idx >= m) a.status = cftb_pkg::ST_BAD;
            else begin
               goal = (64'(ring_ids[rank]) + (64'd1 << idx)) & ((64'd1 << m) - 1);
               a.result_id = ring_ids[0];
               for (int k = ring_count - 1; k >= 0; k--)
                  if (64'(ring_ids[k]) >= goal) a.result_id = ring_ids[k];
            end
         end
      end else begin
         a.status = cftb_pkg::ST_BAD;
      end
      return a;
   endfunction

   // Sends one beat and queues its answer; typed-in answers are checked against the predictor.
   task automatic send_beat(input stim_row_type row);
      answer_type a;
      a = ring_answer(row.func, row.node_id, int'(row.node_rank), int'(row.entry_index));
      if (row.has_answer && (a.result_id !== row.answer_id || a.status !== row.answer_status))
         report_mismatch("table row", {a.result_id[28:0], a.status}, {row.answer_id[28:0],
                         row.answer_status});
      req.valid       <= 1'b1;
      req.func        <= row.func;
      req.node_id     <= row.node_id;
      req.node_rank   <= row.node_rank;
      req.entry_index <= row.entry_index;
      answers_due.insert(answers_due.size(), a);
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic idle_gap(input int n);
      if (n > 0) begin
         req.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic index, input logic [5:0] value);
      while (answers_due.size() != 0) @(posedge clock);
      req.valid <= 1'b0;
      repeat (3 * cftb_pkg::MaxNodes + 8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == cftb_pkg::CSR_ADDR_BITS) width_reg = value;
      else succ_reg = value[4:0];
   endtask

   function automatic stim_row_type mk(input logic [2:0] f, input logic [31:0] id,
                                       input logic [5:0] r, input logic [4:0] x);
      stim_row_type row;
      row = '0;
      row.func = f; row.node_id = id; row.node_rank = r; row.entry_index = x;
      return row;
   endfunction

   function automatic stim_row_type mk_fixed(input stim_row_type row, input logic [31:0] id,
                                             input logic [2:0] st);
      row.has_answer = 1'b1; row.answer_id = id; row.answer_status = st;
      return row;
   endfunction

   function automatic stim_row_type random_row();
      int m;
      int pick;
      logic [31:0] id;
      m = bits_now();
      id = $urandom();
      if (m < 32) id = id & ((32'd1 << m) - 1);
      pick = $urandom_range(0, 99);
      if (pick < 3) id = $urandom();
      if (pick < 35)
         return mk(cftb_pkg::FUNC_LOAD, id, 0, 0);
      if (pick < 93)
         return mk(3'($urandom_range(cftb_pkg::FUNC_PRED, cftb_pkg::FUNC_FING)), id,
                   6'($urandom_range(0, ring_count + 1)),
                   5'($urandom_range(0, 31)));
      if (pick < 96) return mk(cftb_pkg::FUNC_CLEAR, id, 6'($urandom()), 5'($urandom()));
      return mk(3'($urandom_range(5, 7)), $urandom(), 6'($urandom()), 5'($urandom()));
   endfunction

   // Response side: stall pattern, check against the oldest answer.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready   <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         rsp.ready <= (stall_phase % 97 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
         if (rsp.valid && rsp.ready) begin
            if (answers_due.size() == 0)
               report_mismatch("unexpected beat", rsp.result_id, 32'd0);
            else begin
               if (rsp.result_id !== answers_due[0].result_id)
                  report_mismatch("result_id", rsp.result_id, answers_due[0].result_id);
               if (rsp.status !== answers_due[0].status)
                  report_mismatch("status", 32'(rsp.status), 32'(answers_due[0].status));
               void'(answers_due.pop_front());
            end
         end
      end
   end

   // Watchdog on cycles with no beat on either channel.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      int burst;
      logic [5:0] widths[6];
      logic [5:0] lengths[6];
      error_count = 0;
      ring_count = 0;
      width_reg = 6'd32;
      succ_reg = 5'd4;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = cftb_pkg::CSR_ADDR_BITS;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.func = cftb_pkg::FUNC_LOAD;
      req.node_id = '0;
      req.node_rank = '0;
      req.entry_index = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: empty queries, extremes, every operation, empty and bad status codes.
      add_row(mk_fixed(mk(cftb_pkg::FUNC_PRED, 0, 0, 0), 0, cftb_pkg::ST_EMPTY));
      add_row(mk_fixed(mk(cftb_pkg::FUNC_SUCC, 0, 63, 31), 0, cftb_pkg::ST_EMPTY));
      add_row(mk_fixed(mk(cftb_pkg::FUNC_FING, 0, 0, 0), 0, cftb_pkg::ST_EMPTY));
      add_row(mk_fixed(mk(3'd5, 32'hffffffff, 63, 31), 0, cftb_pkg::ST_BAD));
      add_row(mk_fixed(mk(3'd7, 0, 0, 0), 0, cftb_pkg::ST_BAD));
      add_row(mk_fixed(mk(cftb_pkg::FUNC_LOAD, 32'hffffffff, 0, 0), 0, cftb_pkg::ST_OK));
      add_row(mk_fixed(mk(cftb_pkg::FUNC_LOAD, 0, 63, 31), 0, cftb_pkg::ST_OK));
      add_row(mk(cftb_pkg::FUNC_LOAD, 32'h80000000, 0, 0));
      add_row(mk(cftb_pkg::FUNC_LOAD, 32'h80000000, 0, 0));
      add_row(mk(cftb_pkg::FUNC_LOAD, 32'h00001234, 0, 0));
      add_row(mk_fixed(mk(cftb_pkg::FUNC_PRED, 0, 0, 0), 32'hffffffff, cftb_pkg::ST_OK));
      add_row(mk(cftb_pkg::FUNC_PRED, 0, 3, 0));
      add_row(mk(cftb_pkg::FUNC_SUCC, 0, 4, 3));
      add_row(mk_fixed(mk(cftb_pkg::FUNC_SUCC, 0, 0, 4), 0, cftb_pkg::ST_BAD));
      add_row(mk_fixed(mk(cftb_pkg::FUNC_PRED, 0, 5, 0), 0, cftb_pkg::ST_BAD));
      add_row(mk(cftb_pkg::FUNC_FING, 0, 4, 0));
      add_row(mk(cftb_pkg::FUNC_FING, 0, 0, 31));
      add_row(mk(cftb_pkg::FUNC_FING, 0, 2, 31));
      add_row(mk(cftb_pkg::FUNC_FING, 0, 1, 12));
      add_row(mk_fixed(mk(cftb_pkg::FUNC_CLEAR, 32'hffffffff, 63, 31), 0, cftb_pkg::ST_OK));
      add_row(mk_fixed(mk(cftb_pkg::FUNC_FING, 0, 0, 0), 0, cftb_pkg::ST_EMPTY));
      foreach (table_rows[i]) send_beat(table_rows[i]);
      req.valid <= 1'b0;

      // Narrow space: wide ids are refused, and the table is filled to overflow.
      write_reg(cftb_pkg::CSR_ADDR_BITS, 6'd0);
      write_reg(cftb_pkg::CSR_SUCC_LEN, 6'd0);
      send_beat(mk_fixed(mk(cftb_pkg::FUNC_LOAD, 2, 0, 0), 0, cftb_pkg::ST_RANGE));
      for (int i = 0; i < cftb_pkg::MaxNodes + 2; i++)
         send_beat(mk(cftb_pkg::FUNC_LOAD, i & 1, 0, 0));
      send_beat(mk(cftb_pkg::FUNC_FING, 0, 63, 0));
      send_beat(mk_fixed(mk(cftb_pkg::FUNC_FING, 0, 0, 1), 0, cftb_pkg::ST_BAD));
      send_beat(mk(cftb_pkg::FUNC_SUCC, 0, 63, 0));
      send_beat(mk_fixed(mk(cftb_pkg::FUNC_CLEAR, 0, 0, 0), 0, cftb_pkg::ST_OK));
      req.valid <= 1'b0;

      widths  = '{6'd63, 6'd8, 6'd1, 6'd16, 6'd31, 6'd32};
      lengths = '{6'd31, 6'd1, 6'd16, 6'd7, 6'd0, 6'd4};
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(cftb_pkg::CSR_ADDR_BITS, widths[ph]);
         write_reg(cftb_pkg::CSR_SUCC_LEN, lengths[ph]);
         for (int n = 0; n < 110; ) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && n < 110; b++, n++) begin
               row = random_row();
               send_beat(row);
            end
            idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 20));
         end
         req.valid <= 1'b0;
      end

      while (answers_due.size() != 0) @(posedge clock);
      repeat (3 * cftb_pkg::MaxNodes + 8) @(posedge clock);
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

### files.f
src/cftb_pkg.sv
src/cftb_req_if.sv
src/cftb_rsp_if.sv
src/cftb_cell.sv
src/cftb_chain.sv
src/chord_finger_table_builder_top.sv
dv/chord_finger_table_builder_top_test.sv
